// ===== rtl/lc3is_pkg.sv =====
// Shared types, opcodes and helpers for the LC-3 instruction step unit.
package lc3is_pkg;

    localparam int unsigned ADDR_BITS_DEF = 16;
    localparam logic [15:0] START_PC_DEF  = 16'h3000;

    localparam logic [2:0] FLAG_P = 3'd1;
    localparam logic [2:0] FLAG_Z = 3'd2;
    localparam logic [2:0] FLAG_N = 3'd4;

    localparam logic [3:0] OP_BR   = 4'h0;
    localparam logic [3:0] OP_ADD  = 4'h1;
    localparam logic [3:0] OP_LD   = 4'h2;
    localparam logic [3:0] OP_ST   = 4'h3;
    localparam logic [3:0] OP_JSR  = 4'h4;
    localparam logic [3:0] OP_AND  = 4'h5;
    localparam logic [3:0] OP_LDR  = 4'h6;
    localparam logic [3:0] OP_STR  = 4'h7;
    localparam logic [3:0] OP_RTI  = 4'h8;
    localparam logic [3:0] OP_NOT  = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_STI  = 4'hB;
    localparam logic [3:0] OP_JMP  = 4'hC;
    localparam logic [3:0] OP_RES  = 4'hD;
    localparam logic [3:0] OP_LEA  = 4'hE;
    localparam logic [3:0] OP_TRAP = 4'hF;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;

    typedef struct packed {
        logic        func;
        logic [15:0] addr;
        logic [15:0] data;
    } in_item_t;

    typedef struct packed {
        logic [15:0] pc_after;
        logic [2:0]  flags;
        logic        halted;
        logic [15:0] instr_word;
        logic [15:0] write_value;
    } out_item_t;

    // Execute-stage decisions handed from the datapath to the sequencer
    typedef struct packed {
        logic        wr_reg;
        logic        rd_mem;
        logic        wr_mem;
        logic        indirect;
        logic        store_ind;
        logic        set_halt;
        logic [15:0] value;
        logic [15:0] pc_next;
        logic [15:0] addr;
    } exec_t;

    function automatic logic [2:0] flags_of(input logic [15:0] v);
        logic [2:0] f;
        if (v == 16'h0000)
            f = FLAG_Z;
        else if (v[15])
            f = FLAG_N;
        else
            f = FLAG_P;
        return f;
    endfunction

endpackage

// ===== rtl/lc3is_alu.sv =====
// Instruction decode, ALU and address generation for the execute cycle.
module lc3is_alu
(
    input  logic [15:0]          instr,
    input  logic [15:0]          src_a,
    input  logic [15:0]          src_b,
    input  logic [15:0]          pc,
    input  logic [2:0]           flags,
    output lc3is_pkg::exec_t     ex
);

    logic [15:0] off9;
    logic [15:0] off6;
    logic [15:0] imm5;
    logic [15:0] opb;
    logic [15:0] pc_rel;
    logic [15:0] base_rel;

    // Sign-extend the offsets, pick the second operand and form the PC- and base-relative addresses
    assign off9     = {{7{instr[8]}}, instr[8:0]};
    assign off6     = {{10{instr[5]}}, instr[5:0]};
    assign imm5     = {{11{instr[4]}}, instr[4:0]};
    assign opb      = instr[5] ? imm5 : src_b;
    assign pc_rel   = pc + off9;
    assign base_rel = src_a + off6;

    always_comb
    begin
        ex = '0;
        ex.pc_next = pc;
        case (instr[15:12])
            lc3is_pkg::OP_ADD:
            begin
                ex.wr_reg = 1'b1;
                ex.value  = src_a + opb;
            end
            lc3is_pkg::OP_AND:
            begin
                ex.wr_reg = 1'b1;
                ex.value  = src_a & opb;
            end
            lc3is_pkg::OP_NOT:
            begin
                ex.wr_reg = 1'b1;
                ex.value  = ~src_a;
            end
            lc3is_pkg::OP_LEA:
            begin
                ex.wr_reg = 1'b1;
                ex.value  = pc_rel;
            end
            lc3is_pkg::OP_BR:
            begin
                if ((instr[11:9] & flags) != 3'b000)
                    ex.pc_next = pc_rel;
            end
            lc3is_pkg::OP_JMP:
            begin
                ex.pc_next = src_a;
            end
            lc3is_pkg::OP_LDI:
            begin
                ex.rd_mem   = 1'b1;
                ex.indirect = 1'b1;
                ex.addr     = pc_rel;
            end
            lc3is_pkg::OP_LDR:
            begin
                ex.rd_mem = 1'b1;
                ex.addr   = base_rel;
            end
            lc3is_pkg::OP_STI:
            begin
                ex.rd_mem    = 1'b1;
                ex.store_ind = 1'b1;
                ex.addr      = pc_rel;
                ex.value     = src_b;
            end
            lc3is_pkg::OP_ST:
            begin
                ex.wr_mem = 1'b1;
                ex.addr   = pc_rel;
                ex.value  = src_b;
            end
            lc3is_pkg::OP_STR:
            begin
                ex.wr_mem = 1'b1;
                ex.addr   = base_rel;
                ex.value  = src_b;
            end
            lc3is_pkg::OP_RTI, lc3is_pkg::OP_RES:
            begin
                ex.set_halt = 1'b1;
            end
            lc3is_pkg::OP_JSR, lc3is_pkg::OP_LD, lc3is_pkg::OP_TRAP:
            begin
                ex.wr_reg = 1'b0;
            end
            default:
            begin
                ex.wr_reg = 1'b0;
            end
        endcase
    end

endmodule

// ===== rtl/lc3_instruction_step_unit.sv =====
// Top level of the LC-3 instruction step unit: sequencer, memories, beat buffers.
//
//   channel | direction | handshake             | beat
//   --------+-----------+-----------------------+---------------------------------
//   in      | into      | in_valid / in_stall   | in_item: func, addr, data
//   out     | out of    | out_valid / out_stall | out_item: pc, flags, halt, instr, wval
//   cfg     | into      | cfg_valid / cfg_ready | cfg_data: start_pc
//
// Steps per beat: a load beat or a step on a halted core is done while idle;
// ADD, AND, NOT, LEA, BR, JMP, ST, STR and the no-op opcodes take fetch,
// register read and execute; LDR and STI add a memory step, LDI an indirect read
// and a load. A one-entry input buffer takes the next beat during execution.
// After reset the PC loads start_pc before any beat is taken; the register
// file reads zero until written. The final sequencer step holds while a result stalls.
module lc3_instruction_step_unit
#(
    parameter int unsigned ADDR_BITS = lc3is_pkg::ADDR_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  lc3is_pkg::in_item_t   in_item,
    output logic                  out_valid,
    input  logic                  out_stall,
    output lc3is_pkg::out_item_t  out_item,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [15:0]           cfg_data
);

    localparam int unsigned MEM_WORDS = 1 << ADDR_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_IND    = 3'd3;
    localparam logic [2:0] S_LOAD   = 3'd4;
    localparam logic [2:0] S_STI    = 3'd5;

    // Control and architectural registers
    logic [2:0]            state_reg, state_next;
    logic                  init_reg;
    logic [15:0]           start_pc_reg;
    logic [15:0]           pc_reg, pc_next;
    logic [2:0]            flags_reg, flags_next;
    logic                  halt_reg, halt_next;
    logic [15:0]           instr_reg;

    logic                  buf_valid_reg;
    lc3is_pkg::in_item_t   buf_item_reg;
    logic                  out_valid_reg;
    lc3is_pkg::out_item_t  out_item_reg;

    // Word memory port
    logic [15:0]           mem [MEM_WORDS];
    logic                  mem_re, mem_we;
    logic [15:0]           mem_addr_full;
    logic [ADDR_BITS-1:0]  mem_addr;
    logic [15:0]           mem_wdata;
    logic [15:0]           mem_rdata_reg;

    // Register file
    logic [15:0]           rf [8];
    logic [7:0]            rf_valid_reg;
    logic                  rf_re;
    logic [2:0]            rf_ra, rf_rb;
    logic [15:0]           rf_a_reg, rf_b_reg;
    logic                  rf_we;
    logic [15:0]           rf_wdata;

    logic                  take;
    logic                  accept;
    logic                  out_free;
    logic                  emit;
    lc3is_pkg::out_item_t  emit_item;
    lc3is_pkg::exec_t      ex;

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = buf_valid_reg && !take;
    assign accept    = in_valid && !in_stall;
    assign mem_addr  = mem_addr_full[ADDR_BITS-1:0];

    lc3is_alu u_alu
    (
        .instr (instr_reg),
        .src_a (rf_a_reg),
        .src_b (rf_b_reg),
        .pc    (pc_reg),
        .flags (flags_reg),
        .ex    (ex)
    );

    // Sequencer: one beat at a time through fetch, read, execute and memory steps
    always_comb
    begin
        state_next    = state_reg;
        pc_next       = pc_reg;
        flags_next    = flags_reg;
        halt_next     = halt_reg;
        take          = 1'b0;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        mem_addr_full = pc_reg;
        mem_wdata     = buf_item_reg.data;
        rf_re         = 1'b0;
        rf_ra         = mem_rdata_reg[8:6];
        rf_rb         = mem_rdata_reg[2:0];
        rf_we         = 1'b0;
        rf_wdata      = mem_rdata_reg;
        emit          = 1'b0;
        emit_item     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (init_reg && buf_valid_reg)
                begin
                    if (buf_item_reg.func == lc3is_pkg::FUNC_STEP && !halt_reg)
                    begin
                        take      = 1'b1;
                        mem_re    = 1'b1;
                        state_next = S_DECODE;
                    end
                    else if (out_free)
                    begin
                        take = 1'b1;
                        emit = 1'b1;
                        emit_item.pc_after = pc_reg;
                        emit_item.flags    = flags_reg;
                        emit_item.halted   = halt_reg;
                        if (buf_item_reg.func == lc3is_pkg::FUNC_LOAD)
                        begin
                            mem_we                = 1'b1;
                            mem_addr_full         = buf_item_reg.addr;
                            emit_item.write_value = buf_item_reg.data;
                        end
                    end
                end
            end
            S_DECODE:
            begin
                rf_re   = 1'b1;
                pc_next = pc_reg + 16'd1;
                if (mem_rdata_reg[15:12] inside {lc3is_pkg::OP_ST, lc3is_pkg::OP_STI,
                                                 lc3is_pkg::OP_STR})
                    rf_rb = mem_rdata_reg[11:9];
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                mem_addr_full = ex.addr;
                mem_wdata     = ex.value;
                if (ex.rd_mem)
                begin
                    mem_re = 1'b1;
                    if (ex.indirect)
                        state_next = S_IND;
                    else if (ex.store_ind)
                        state_next = S_STI;
                    else
                        state_next = S_LOAD;
                end
                else if (out_free)
                begin
                    mem_we   = ex.wr_mem;
                    rf_we    = ex.wr_reg;
                    rf_wdata = ex.value;
                    pc_next  = ex.pc_next;
                    if (ex.wr_reg)
                        flags_next = lc3is_pkg::flags_of(ex.value);
                    if (ex.set_halt)
                        halt_next = 1'b1;
                    emit = 1'b1;
                    emit_item.pc_after    = ex.pc_next;
                    emit_item.flags       = ex.wr_reg ? lc3is_pkg::flags_of(ex.value)
                                                      : flags_reg;
                    emit_item.halted      = halt_reg || ex.set_halt;
                    emit_item.instr_word  = instr_reg;
                    emit_item.write_value = ex.value;
                    state_next = S_IDLE;
                end
            end
            S_IND:
            begin
                mem_re        = 1'b1;
                mem_addr_full = mem_rdata_reg;
                state_next    = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    rf_we      = 1'b1;
                    rf_wdata   = mem_rdata_reg;
                    flags_next = lc3is_pkg::flags_of(mem_rdata_reg);
                    emit = 1'b1;
                    emit_item.pc_after    = pc_reg;
                    emit_item.flags       = lc3is_pkg::flags_of(mem_rdata_reg);
                    emit_item.halted      = halt_reg;
                    emit_item.instr_word  = instr_reg;
                    emit_item.write_value = mem_rdata_reg;
                    state_next = S_IDLE;
                end
            end
            S_STI:
            begin
                mem_addr_full = mem_rdata_reg;
                mem_wdata     = rf_b_reg;
                if (out_free)
                begin
                    mem_we = 1'b1;
                    emit = 1'b1;
                    emit_item.pc_after    = pc_reg;
                    emit_item.flags       = flags_reg;
                    emit_item.halted      = halt_reg;
                    emit_item.instr_word  = instr_reg;
                    emit_item.write_value = rf_b_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance control state, architectural registers and beat buffers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            init_reg      <= 1'b0;
            start_pc_reg  <= lc3is_pkg::START_PC_DEF;
            pc_reg        <= lc3is_pkg::START_PC_DEF;
            flags_reg     <= lc3is_pkg::FLAG_Z;
            halt_reg      <= 1'b0;
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            rf_valid_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            flags_reg <= flags_next;
            halt_reg  <= halt_next;
            init_reg  <= 1'b1;
            if (!init_reg)
                pc_reg <= start_pc_reg;
            else
                pc_reg <= pc_next;
            if (cfg_valid && cfg_ready)
                start_pc_reg <= cfg_data;
            if (accept)
                buf_valid_reg <= 1'b1;
            else if (take)
                buf_valid_reg <= 1'b0;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            if (rf_we)
                rf_valid_reg[instr_reg[11:9]] <= 1'b1;
        end
    end

    // Hold beat payloads and the fetched instruction word
    always_ff @(posedge clk)
    begin
        if (accept)
            buf_item_reg <= in_item;
        if (emit)
            out_item_reg <= emit_item;
        if (state_reg == S_DECODE)
            instr_reg <= mem_rdata_reg;
    end

    // Word memory: one access per cycle, registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        else if (mem_re)
            mem_rdata_reg <= mem[mem_addr];
    end

    // Register file: two registered reads, one write; unwritten entries read zero
    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf[instr_reg[11:9]] <= rf_wdata;
        if (rf_re)
        begin
            rf_a_reg <= rf_valid_reg[rf_ra] ? rf[rf_ra] : 16'h0000;
            rf_b_reg <= rf_valid_reg[rf_rb] ? rf[rf_rb] : 16'h0000;
        end
    end

    // Halt is sticky until reset
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared without reset");

    // The single memory port never reads and writes in one cycle
    a_mem_one_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("memory read and write in the same cycle");

    // A waiting result is never overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !emit)
        else $error("result beat overwritten while stalled");

    // Condition code stays one-hot
    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(flags_reg))
        else $error("condition code not one-hot");

    // Register and memory writes of an instruction happen only when its result leaves the sequencer
    a_state_with_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (rf_we || (mem_we && state_reg != S_IDLE)) |-> emit)
        else $error("state written without a result beat");

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the LC-3 instruction step unit.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_LIMIT = 3000;
    localparam int unsigned PHASE_BEATS = 600;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    lc3is_pkg::in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    lc3is_pkg::out_item_t out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [15:0] cfg_data = 16'h0000;

    // Beats waiting for the driver and results the core still owes
    lc3is_pkg::in_item_t beats_to_send[$];
    lc3is_pkg::out_item_t results_due[$];

    // Shadow architectural state of the core
    logic [15:0] mem_img [0:65535];
    bit mem_known [0:65535];
    logic [15:0] gpr [0:7];
    logic [15:0] pc_m = lc3is_pkg::START_PC_DEF;
    logic [2:0] cc_m = lc3is_pkg::FLAG_Z;
    bit core_halted = 1'b0;

    int unsigned beats_made = 0;
    int unsigned fail_count = 0;
    int unsigned idle_cycles = 0;
    int unsigned in_gap = 0;
    int unsigned stall_left = 0;
    bit in_fire = 1'b0;
    bit calm = 1'b0;

    lc3_instruction_step_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Mostly short gaps, a few long ones, none at all in calm stretches
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] set_gpr(input logic [2:0] r, input logic [15:0] v);
        gpr[r] = v;
        if (v == 16'h0000)
            cc_m = lc3is_pkg::FLAG_Z;
        else if (v[15])
            cc_m = lc3is_pkg::FLAG_N;
        else
            cc_m = lc3is_pkg::FLAG_P;
        return v;
    endfunction

    function automatic void mem_store(input logic [15:0] a, input logic [15:0] v);
        mem_img[a] = v;
        mem_known[a] = 1'b1;
    endfunction

    // Advance the shadow core by one beat and record the result it owes
    function automatic void step_core(input lc3is_pkg::in_item_t it);
        lc3is_pkg::out_item_t r;
        logic [15:0] ins;
        logic [15:0] wv;
        logic [15:0] opb;
        logic [15:0] off9;
        logic [15:0] off6;
        logic [15:0] ptr;
        logic [2:0] dr;
        logic [2:0] sr1;
        ins = 16'h0000;
        wv = 16'h0000;
        if (it.func == lc3is_pkg::FUNC_LOAD)
        begin
            wv = it.data;
            mem_store(it.addr, it.data);
        end
        else if (!core_halted)
        begin
            ins = mem_img[pc_m];
            pc_m = pc_m + 16'd1;
            dr = ins[11:9];
            sr1 = ins[8:6];
            off9 = {{7{ins[8]}}, ins[8:0]};
            off6 = {{10{ins[5]}}, ins[5:0]};
            opb = ins[5] ? {{11{ins[4]}}, ins[4:0]} : gpr[ins[2:0]];
            case (ins[15:12])
                lc3is_pkg::OP_ADD: wv = set_gpr(dr, gpr[sr1] + opb);
                lc3is_pkg::OP_AND: wv = set_gpr(dr, gpr[sr1] & opb);
                lc3is_pkg::OP_NOT: wv = set_gpr(dr, ~gpr[sr1]);
                lc3is_pkg::OP_BR:
                begin
                    if ((dr & cc_m) != 3'd0)
                        pc_m = pc_m + off9;
                end
                lc3is_pkg::OP_JMP: pc_m = gpr[sr1];
                lc3is_pkg::OP_LDI:
                begin
                    ptr = mem_img[16'(pc_m + off9)];
                    wv = set_gpr(dr, mem_img[ptr]);
                end
                lc3is_pkg::OP_LDR: wv = set_gpr(dr, mem_img[16'(gpr[sr1] + off6)]);
                lc3is_pkg::OP_LEA: wv = set_gpr(dr, pc_m + off9);
                lc3is_pkg::OP_ST:
                begin
                    wv = gpr[dr];
                    mem_store(pc_m + off9, wv);
                end
                lc3is_pkg::OP_STI:
                begin
                    wv = gpr[dr];
                    mem_store(mem_img[16'(pc_m + off9)], wv);
                end
                lc3is_pkg::OP_STR:
                begin
                    wv = gpr[dr];
                    mem_store(gpr[sr1] + off6, wv);
                end
                lc3is_pkg::OP_RTI, lc3is_pkg::OP_RES: core_halted = 1'b1;
                default: ;
            endcase
        end
        r.pc_after = pc_m;
        r.flags = cc_m;
        r.halted = core_halted;
        r.instr_word = ins;
        r.write_value = wv;
        results_due.push_back(r);
    endfunction

    function automatic void queue_beat(input lc3is_pkg::in_item_t it);
        beats_to_send.push_back(it);
        step_core(it);
        beats_made++;
    endfunction

    function automatic void queue_load(input logic [15:0] a, input logic [15:0] d);
        lc3is_pkg::in_item_t it;
        it.func = lc3is_pkg::FUNC_LOAD;
        it.addr = a;
        it.data = d;
        queue_beat(it);
    endfunction

    // Make sure a word the core will read has been written
    function automatic void fill_word(input logic [15:0] a);
        if (!mem_known[a])
            queue_load(a, 16'($urandom));
    endfunction

    // Place an instruction at the PC (or reuse the word there), back its
    // operand reads with written words, then execute it
    function automatic void run_instr(input logic [15:0] ins, input bit reuse);
        lc3is_pkg::in_item_t it;
        logic [15:0] cur;
        logic [15:0] off9;
        logic [15:0] off6;
        logic [15:0] ea;
        if (!core_halted)
        begin
            cur = mem_img[pc_m];
            if (!(reuse && mem_known[pc_m]) || cur[15:12] == lc3is_pkg::OP_RTI ||
                cur[15:12] == lc3is_pkg::OP_RES)
                queue_load(pc_m, ins);
            cur = mem_img[pc_m];
            off9 = {{7{cur[8]}}, cur[8:0]};
            off6 = {{10{cur[5]}}, cur[5:0]};
            ea = pc_m + 16'd1 + off9;
            case (cur[15:12])
                lc3is_pkg::OP_LDI:
                begin
                    fill_word(ea);
                    fill_word(mem_img[ea]);
                end
                lc3is_pkg::OP_STI: fill_word(ea);
                lc3is_pkg::OP_LDR: fill_word(gpr[cur[8:6]] + off6);
                default: ;
            endcase
        end
        it.func = lc3is_pkg::FUNC_STEP;
        it.addr = 16'($urandom);
        it.data = 16'($urandom);
        queue_beat(it);
    endfunction

    function automatic logic [15:0] random_instr();
        logic [3:0] op;
        do
            op = 4'($urandom_range(0, 15));
        while (op == lc3is_pkg::OP_RTI || op == lc3is_pkg::OP_RES);
        return {op, 12'($urandom)};
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            fail_count++;
        end
    endfunction

    // Wait until every beat is sent and every result has come back
    task automatic wait_drained();
        while (beats_to_send.size() != 0 || in_valid || results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write start_pc while the core is idle
    task automatic write_start_pc(input logic [15:0] v);
        @(negedge clk);
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Input driver: hold a stalled beat, otherwise idle or present the next one
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!(in_valid && !in_fire))
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (beats_to_send.size() != 0)
            begin
                in_item <= beats_to_send.pop_front();
                in_valid <= 1'b1;
                in_gap <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Output stall pattern; switch calm stretches on and off now and then
    always @(negedge clk)
    begin
        if ($urandom_range(0, 149) == 0)
            calm <= ~calm;
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left <= pick_gap();
        end
    end

    // Monitor: record input acceptance, check results, run the watchdog
    always @(posedge clk)
    begin
        lc3is_pkg::out_item_t want;
        if (rst_n)
        begin
            in_fire <= in_valid && !in_stall;
            if (out_valid && !out_stall)
            begin
                if (results_due.size() == 0)
                begin
                    $error("unexpected result beat: pc_after %h", out_item.pc_after);
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    check_field("pc_after", want.pc_after, out_item.pc_after);
                    check_field("flags", 16'(want.flags), 16'(out_item.flags));
                    check_field("halted", 16'(want.halted), 16'(out_item.halted));
                    check_field("instr_word", want.instr_word, out_item.instr_word);
                    check_field("write_value", want.write_value, out_item.write_value);
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("tb_top: done, errors");
                $finish;
            end
        end
    end

    // Stimulus: directed program, random phases between start_pc writes, halt
    initial
    begin
        int unsigned goal;
        int unsigned r;
        logic [15:0] cfg_vals [0:3];
        for (int i = 0; i < 8; i++)
            gpr[i] = 16'h0000;
        cfg_vals[0] = 16'hFFFF;
        cfg_vals[1] = 16'h0000;
        cfg_vals[2] = 16'($urandom);
        cfg_vals[3] = lc3is_pkg::START_PC_DEF;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        write_start_pc(cfg_vals[0]);

        // Directed: field extremes, every opcode but RTI and RES, wraparound of the PC
        queue_load(16'h0000, 16'h0000);
        queue_load(16'hFFFF, 16'hFFFF);
        run_instr(16'h127F, 1'b0);  // ADD R1, R1, #-1
        run_instr(16'h1441, 1'b0);  // ADD R2, R1, R1
        run_instr(16'h566F, 1'b0);  // AND R3, R1, #15
        run_instr(16'h5840, 1'b0);  // AND R4, R1, R0: zero result
        run_instr(16'h0005, 1'b0);  // BR with no condition bits: never taken
        run_instr(16'h9AFF, 1'b0);  // NOT R5, R3
        run_instr(16'h0803, 1'b0);  // BRn forward, taken
        run_instr(16'hED00, 1'b0);  // LEA R6, most negative offset
        run_instr(16'h32FF, 1'b0);  // ST R1, most positive offset
        run_instr(16'h7720, 1'b0);  // STR R3 at R4 - 32 (address wraps)
        run_instr(16'h6F20, 1'b0);  // LDR R7 from the same word
        run_instr(16'hB405, 1'b0);  // STI R2
        run_instr(16'hA1FF, 1'b0);  // LDI R0 through its own instruction word
        run_instr(16'h4800, 1'b0);  // JSR: no effect beyond the fetch
        run_instr(16'h2E00, 1'b0);  // LD: no effect beyond the fetch
        run_instr(16'hF025, 1'b0);  // TRAP: no effect beyond the fetch
        run_instr(16'hC040, 1'b0);  // JMP R1 to 0xFFFF
        run_instr(16'h1021, 1'b0);  // executes at 0xFFFF, PC wraps to 0
        wait_drained();

        // Random programs, with stray loads and reuse of words already in memory
        for (int ph = 1; ph < 4; ph++)
        begin
            write_start_pc(cfg_vals[ph]);
            goal = beats_made + PHASE_BEATS;
            while (beats_made < goal)
            begin
                r = $urandom_range(0, 99);
                if (r < 6)
                    queue_load(16'($urandom), 16'($urandom));
                else
                    run_instr(random_instr(), r < 30);
            end
            wait_drained();
        end

        // Halt, then steps that the halted core ignores and loads it still takes
        run_instr(random_instr(), 1'b0);
        run_instr($urandom_range(0, 1) ? {lc3is_pkg::OP_RTI, 12'($urandom)}
                                       : {lc3is_pkg::OP_RES, 12'($urandom)},
                  1'b0);
        queue_load(pc_m, {lc3is_pkg::OP_RTI, 12'($urandom)});
        run_instr(16'h0000, 1'b0);
        queue_load(pc_m, {lc3is_pkg::OP_RES, 12'($urandom)});
        run_instr(16'h0000, 1'b0);
        queue_load(16'($urandom), 16'($urandom));
        run_instr(16'h0000, 1'b0);
        wait_drained();
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
